[rtl/mkc_pkg.sv]
// Package for the motor kick-start command controller.
// Holds the word types, register and command codes and small helpers.
// No dependencies.
`default_nettype none

package mkc_pkg;

  localparam int FULL_DUTY = 1023;
  localparam int AGE_WIDTH = 16;

  localparam int DUTY_W = 10;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 3;

  localparam logic [DUTY_W-1:0] FULL_DUTY_CODE = DUTY_W'(FULL_DUTY);

  // register indexes
  localparam logic [IDX_W-1:0] REG_DEVICE_KIND    = 3'd0;
  localparam logic [IDX_W-1:0] REG_KICK_TICKS     = 3'd1;
  localparam logic [IDX_W-1:0] REG_WATCHDOG_TICKS = 3'd2;
  localparam logic [IDX_W-1:0] REG_BLINK_TICKS    = 3'd3;
  localparam logic [IDX_W-1:0] REG_RUN_DUTY       = 3'd4;

  // device kinds
  localparam logic [2:0] KIND_WIND  = 3'd0;
  localparam logic [2:0] KIND_PLAIN = 3'd1;
  localparam logic [2:0] KIND_ATOM  = 3'd2;
  localparam logic [2:0] KIND_RGB   = 3'd3;

  // actions and command codes
  localparam logic       ACT_TICK  = 1'b0;
  localparam logic       ACT_CMD   = 1'b1;
  localparam logic [2:0] CMD_BLINK = 3'd0;
  localparam logic [2:0] CMD_RGB   = 3'd1;
  localparam logic [2:0] CMD_ON    = 3'd2;
  localparam logic [2:0] CMD_OFF   = 3'd3;

  localparam logic [7:0] PCT_MAX = 8'd100;

  typedef logic [AGE_WIDTH-1:0] age_t;

  typedef struct packed {
    logic       action;
    logic [2:0] cmd_code;
    logic [7:0] payload_len;
    logic [7:0] payload_0;
    logic [7:0] payload_1;
    logic [7:0] payload_2;
  } in_word_t;

  typedef struct packed {
    logic [DUTY_W-1:0] drive_duty;
    logic              status_led;
    logic [7:0]        rgb_red;
    logic [7:0]        rgb_green;
    logic [7:0]        rgb_blue;
    logic              atomizer_on;
  } out_word_t;

  typedef struct packed {
    logic [2:0]        device_kind;
    logic [15:0]       kick_ticks;
    logic [15:0]       watchdog_ticks;
    logic [15:0]       blink_ticks;
    logic [DUTY_W-1:0] run_duty;
  } cfg_t;

  typedef struct packed {
    logic [6:0]        request_percent;
    logic              watchdog_armed;
    age_t              command_age;
    logic              motor_active;
    logic              kick_active;
    age_t              kick_age;
    logic [DUTY_W-1:0] duty_now;
    logic              led_active;
    age_t              led_age;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic              atomizer_want;
  } state_t;

  function automatic age_t age_inc(input age_t a);
    return (a == '1) ? a : a + 1'b1;
  endfunction

  // age >= ticks with both zero-extended, so any AGE_WIDTH up to 33 compares right
  function automatic logic age_ge(input age_t a, input logic [15:0] t);
    return 33'(a) >= 33'(t);
  endfunction

endpackage

`default_nettype wire

[rtl/mkc_if.sv]
// Valid/ready channel interfaces for input and result words.
// Depends on mkc_pkg.
`default_nettype none

interface mkc_in_if;
  import mkc_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mkc_out_if;
  import mkc_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/mkc_step.sv]
// Next-state logic for one word: tick aging, command decode, motor update
// and LED pulse end. Purely combinational. Depends on mkc_pkg.
`default_nettype none

module mkc_step (
  input  wire mkc_pkg::cfg_t     cfg,
  input  wire mkc_pkg::state_t   st,
  input  wire mkc_pkg::in_word_t word,
  output mkc_pkg::state_t        st_next
);
  import mkc_pkg::*;

  logic actuator;
  logic motor_kind;
  logic wind;

  assign actuator   = (cfg.device_kind <= KIND_ATOM);
  assign motor_kind = (cfg.device_kind <= KIND_PLAIN);
  assign wind       = (cfg.device_kind == KIND_WIND);

  always_comb begin
    state_t s;
    s = st;

    if (word.action == ACT_TICK) begin
      if (s.watchdog_armed) s.command_age = age_inc(s.command_age);
      if (s.kick_active)    s.kick_age    = age_inc(s.kick_age);
      if (s.led_active)     s.led_age     = age_inc(s.led_age);
    end else begin
      case (word.cmd_code)
        CMD_BLINK: begin
          if (word.payload_len == 8'd0) begin
            s.led_active = 1'b1;
            s.led_age    = '0;
          end
        end
        CMD_RGB: begin
          if (word.payload_len == 8'd3 && cfg.device_kind == KIND_RGB) begin
            s.red   = word.payload_0;
            s.green = word.payload_1;
            s.blue  = word.payload_2;
          end
        end
        CMD_ON: begin
          if (actuator && word.payload_len == 8'd1 && word.payload_0 != 8'd0 &&
              word.payload_0 <= PCT_MAX) begin
            s.request_percent = word.payload_0[6:0];
            s.command_age     = '0;
            s.watchdog_armed  = 1'b1;
            if (cfg.device_kind == KIND_ATOM) s.atomizer_want = 1'b1;
          end
        end
        CMD_OFF: begin
          if (actuator && word.payload_len == 8'd0) begin
            s.request_percent = '0;
            s.command_age     = '0;
            s.watchdog_armed  = 1'b1;
            if (cfg.device_kind == KIND_ATOM) s.atomizer_want = 1'b0;
          end
        end
        default: ;
      endcase
    end

    if (motor_kind) begin
      if (s.watchdog_armed && age_ge(s.command_age, cfg.watchdog_ticks)) begin
        s.watchdog_armed  = 1'b0;
        s.request_percent = '0;
      end
      if (s.request_percent == '0) begin
        s.motor_active = 1'b0;
        s.kick_active  = 1'b0;
        s.duty_now     = '0;
      end else if (!s.motor_active) begin
        s.motor_active = 1'b1;
        s.duty_now     = FULL_DUTY_CODE;
        if (wind) begin
          s.kick_active = 1'b1;
          s.kick_age    = '0;
        end
      end else if (wind) begin
        // kick holds full duty until its time is up
        if (!(s.kick_active && !age_ge(s.kick_age, cfg.kick_ticks))) begin
          s.kick_active = 1'b0;
          s.duty_now    = cfg.run_duty;
        end
      end else begin
        s.duty_now = FULL_DUTY_CODE;
      end
    end

    if (s.led_active && age_ge(s.led_age, cfg.blink_ticks)) s.led_active = 1'b0;

    st_next = s;
  end

endmodule

`default_nettype wire

[rtl/motor_kick_start_command_controller.sv]
// Motor kick-start command controller, top level.
// Depends on mkc_pkg, mkc_if and mkc_step.
//
// Each accepted input word (a millisecond tick or a bus command) has its
// result word in the output register on the next cycle; one word per cycle
// is sustained while results are taken. The state update for a word is a
// single pass of logic in mkc_step between the state registers and the
// result register. A new word enters in the same cycle the waiting result is
// taken; a stalled result holds off the input. Configuration writes take
// effect on the next cycle.
`default_nettype none

module motor_kick_start_command_controller (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [mkc_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [mkc_pkg::CFG_W-1:0] cfg_data,
  mkc_in_if.sink                        cmd,
  mkc_out_if.source                     res
);
  import mkc_pkg::*;

  cfg_t      cfg;
  state_t    st;
  state_t    st_next;
  logic      res_valid;
  out_word_t res_data;
  logic      take;

  assign cmd.ready = !res_valid || res.ready;
  assign take      = cmd.valid && cmd.ready;
  assign res.valid = res_valid;
  assign res.data  = res_data;

  mkc_step u_step (
    .cfg     (cfg),
    .st      (st),
    .word    (cmd.data),
    .st_next (st_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_kind    <= KIND_WIND;
      cfg.kick_ticks     <= 16'd300;
      cfg.watchdog_ticks <= 16'd10000;
      cfg.blink_ticks    <= 16'd100;
      cfg.run_duty       <= 10'd802;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEVICE_KIND:    cfg.device_kind    <= cfg_data[2:0];
        REG_KICK_TICKS:     cfg.kick_ticks     <= cfg_data;
        REG_WATCHDOG_TICKS: cfg.watchdog_ticks <= cfg_data;
        REG_BLINK_TICKS:    cfg.blink_ticks    <= cfg_data;
        REG_RUN_DUTY:       cfg.run_duty       <= cfg_data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.request_percent <= '0;
      st.watchdog_armed  <= 1'b0;
      st.command_age     <= '0;
      st.motor_active    <= 1'b0;
      st.kick_active     <= 1'b0;
      st.kick_age        <= '0;
      st.duty_now        <= '0;
      st.led_active      <= 1'b0;
      st.led_age         <= '0;
      st.red             <= 8'd5;
      st.green           <= 8'd0;
      st.blue            <= 8'd5;
      st.atomizer_want   <= 1'b0;
    end else if (take) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_data.drive_duty  <= st_next.duty_now;
      res_data.status_led  <= st_next.led_active;
      res_data.rgb_red     <= st_next.red;
      res_data.rgb_green   <= st_next.green;
      res_data.rgb_blue    <= st_next.blue;
      res_data.atomizer_on <= st_next.atomizer_want;
    end
  end

endmodule

`default_nettype wire

[rtl/mkc_checker.sv]
// Port-level checks for the motor kick-start command controller, and the
// bind that attaches them. Depends on mkc_pkg and the top level.
`default_nettype none

module mkc_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               cmd_valid,
  input wire logic               cmd_ready,
  input wire logic               res_valid,
  input wire logic               res_ready,
  input wire mkc_pkg::out_word_t res_data
);
  import mkc_pkg::*;

  // every accepted word yields a result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> res_valid)
    else $error("accepted word produced no result");

  // a waiting result must block new input
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |-> !cmd_ready)
    else $error("input taken while result stalled");

  // a taken result with nothing new behind it leaves the output empty
  a_no_repeat: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && !(cmd_valid && cmd_ready) |=> !res_valid)
    else $error("result word repeated");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("stalled result changed");

endmodule

bind motor_kick_start_command_controller mkc_checker u_mkc_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd.valid),
  .cmd_ready (cmd.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_data  (res.data)
);

`default_nettype wire
